// ----- rtl/lrip_pkg.sv -----
// ---------------------------------------------------------------------------
// lrip_pkg
// Shared types and constants for the lidar ray incidence pruner.
// ---------------------------------------------------------------------------
package lrip_pkg;

  localparam int RANGE_BITS  = 16;  // significant bits of an incoming range
  localparam int FRAC_BITS   = 15;  // fraction bits of the Q1.15 registers
  localparam int RW          = 16;  // range field width
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RW-1:0] RANGE_MASK = RW'((64'd1 << RANGE_BITS) - 64'd1);

  // Configuration register indexes
  localparam logic [1:0] REG_SIN_INC   = 2'd0;
  localparam logic [1:0] REG_COS_INC   = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_MAX_RANGE = 2'd3;

  // Reset values of the configuration registers
  localparam logic [15:0]          SIN_INC_RST   = 16'd143;
  localparam logic [FRAC_BITS-1:0] COS_INC_RST   = FRAC_BITS'(32767);
  localparam logic [FRAC_BITS-1:0] THRESHOLD_RST = FRAC_BITS'(18055);
  localparam logic [RW-1:0]        MAX_RANGE_RST = RW'(5600);

  typedef logic [RW-1:0] range_t;

  typedef struct packed {
    logic [15:0]          sin_inc;    // signed Q1.15 pattern
    logic [FRAC_BITS-1:0] cos_inc;
    logic [FRAC_BITS-1:0] thr;
    range_t               max_range;
  } cfg_t;

  // One unit of back-end work: a held ray judged against the next one,
  // optionally followed by the final ray of the scan.
  typedef struct packed {
    range_t a;         // held range
    range_t b;         // current range
    logic   has_held;  // a is valid
    logic   last;      // b closes the scan
  } job_t;

endpackage

// ----- rtl/lrip_if.sv -----
// ---------------------------------------------------------------------------
// lrip_in_if / lrip_out_if
// Valid/ready channels carrying lidar ranges in and pruning results out.
// ---------------------------------------------------------------------------
interface lrip_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        last_in_scan;

  modport source (output valid, output range_mm, output last_in_scan, input ready);
  modport sink   (input valid, input range_mm, input last_in_scan, output ready);
endinterface

interface lrip_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_out;
  logic        pruned;
  logic        scan_end;

  modport source (output valid, output range_out, output pruned, output scan_end,
                  input ready);
  modport sink   (input valid, input range_out, input pruned, input scan_end,
                  output ready);
endinterface

// ----- rtl/lrip_front.sv -----
// ---------------------------------------------------------------------------
// lrip_front
// Accepts ranges, keeps the held sample and turns ray pairs into jobs.
// ---------------------------------------------------------------------------
module lrip_front (
  input  logic              clk,
  input  logic              rst_n,
  lrip_in_if.sink           in_chan,
  input  logic              q_full,
  output logic              q_push,
  output lrip_pkg::job_t    q_job
);

  lrip_pkg::range_t held_r, held_nxt;
  logic             present_r, present_nxt;
  lrip_pkg::range_t cur;
  logic             take;

  assign in_chan.ready = !q_full;
  assign take          = in_chan.valid && !q_full;
  assign cur           = in_chan.range_mm & lrip_pkg::RANGE_MASK;

  // A job exists whenever a result is due: a held ray, or the end of a scan.
  assign q_push        = take && (present_r || in_chan.last_in_scan);
  assign q_job.a        = held_r;
  assign q_job.b        = cur;
  assign q_job.has_held = present_r;
  assign q_job.last     = in_chan.last_in_scan;

  always_comb begin
    held_nxt    = held_r;
    present_nxt = present_r;
    if (take) begin
      if (in_chan.last_in_scan) begin
        held_nxt    = '0;
        present_nxt = 1'b0;
      end else begin
        held_nxt    = cur;
        present_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      present_r <= 1'b0;
    end else begin
      held_r    <= held_nxt;
      present_r <= present_nxt;
    end
  end

endmodule

// ----- rtl/lrip_queue.sv -----
// ---------------------------------------------------------------------------
// lrip_queue
// Small job FIFO between the front end and the incidence unit.
// ---------------------------------------------------------------------------
module lrip_queue #(
  parameter int DEPTH = lrip_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lrip_pkg::job_t din,
  input  logic           pop,
  output lrip_pkg::job_t dout,
  output logic           full,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lrip_pkg::job_t mem [DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/lrip_back.sv -----
// ---------------------------------------------------------------------------
// lrip_back
// Incidence unit: runs the squared sine test for one job and emits results.
// ---------------------------------------------------------------------------
module lrip_back (
  input  logic           clk,
  input  logic           rst_n,
  input  lrip_pkg::cfg_t cfg,
  input  logic           job_valid,
  input  lrip_pkg::job_t job_head,
  output logic           job_pop,
  lrip_out_if.source     out_chan
);

  localparam int RW      = lrip_pkg::RW;
  localparam int FW      = lrip_pkg::FRAC_BITS;
  localparam int LMAG_W  = RW + FW;
  localparam int LSQ_W   = 2 * LMAG_W;
  localparam int SQ_W    = 2 * RW;
  localparam int SUM_W   = SQ_W + 1;
  localparam int CROSS_W = SQ_W + FW;
  localparam int R2_W    = SUM_W + FW;
  localparam int THR2_W  = 2 * FW;
  localparam int HALF    = R2_W / 2;
  localparam int PP_W    = (R2_W - HALF) + THR2_W;
  localparam int CMP_W   = R2_W + THR2_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL1  = 7'b0000010,
    ST_MUL2  = 7'b0000100,
    ST_SUB   = 7'b0001000,
    ST_MUL3  = 7'b0010000,
    ST_CMP   = 7'b0100000,
    ST_EMIT2 = 7'b1000000
  } state_t;

  state_t         state_r, state_nxt;
  lrip_pkg::job_t job_r, job_nxt;
  logic           last_pr_r, last_pr_nxt;

  logic                 out_valid_r, out_valid_nxt;
  lrip_pkg::range_t     out_range_r, out_range_nxt;
  logic                 out_pruned_r, out_pruned_nxt;
  logic                 out_end_r, out_end_nxt;

  // datapath stage registers
  logic [LMAG_W-1:0]  lmag_r;
  logic [SQ_W-1:0]    aa_r, bb_r, ab_r;
  logic [THR2_W-1:0]  thr2_r;
  logic               special_r, special_val_r;
  logic [LSQ_W-1:0]   lsq_r;
  logic [CROSS_W-1:0] cross_r;
  logic [SUM_W-1:0]   tot_r;
  logic [R2_W-1:0]    r2_r;
  logic [PP_W-1:0]    ph_r;
  logic [PP_W-1:0]    pl_r;

  logic               neg;
  logic [FW-1:0]      smag_pos;
  logic [R2_W-1:0]    tot_s, cross_s;
  logic [CMP_W-1:0]   left_v, right_v;
  logic               pr;
  logic               load_ok;

  assign neg      = cfg.sin_inc[15];
  assign smag_pos = neg ? '0 : FW'(cfg.sin_inc[14:0]);
  assign tot_s    = {tot_r, {FW{1'b0}}};
  assign cross_s  = R2_W'({cross_r, 1'b0});
  assign left_v   = CMP_W'({lsq_r, {FW{1'b0}}});
  assign right_v  = (CMP_W'(ph_r) << HALF) + CMP_W'(pl_r);
  assign pr       = special_r ? special_val_r : (left_v < right_v);

  // Free-running datapath; job_r is stable while the sequencer walks it.
  always_ff @(posedge clk) begin
    lmag_r        <= LMAG_W'(job_r.b) * LMAG_W'(smag_pos);
    aa_r          <= SQ_W'(job_r.a) * SQ_W'(job_r.a);
    bb_r          <= SQ_W'(job_r.b) * SQ_W'(job_r.b);
    ab_r          <= SQ_W'(job_r.a) * SQ_W'(job_r.b);
    thr2_r        <= THR2_W'(cfg.thr) * THR2_W'(cfg.thr);
    special_r     <= (job_r.a == '0) || (neg && (job_r.b != '0));
    special_val_r <= (job_r.a == '0) ? (cfg.thr != '0) : 1'b1;
    lsq_r         <= LSQ_W'(lmag_r) * LSQ_W'(lmag_r);
    cross_r       <= CROSS_W'(ab_r) * CROSS_W'(cfg.cos_inc);
    tot_r         <= SUM_W'(aa_r) + SUM_W'(bb_r);
    r2_r          <= (tot_s >= cross_s) ? (tot_s - cross_s) : '0;
    ph_r          <= PP_W'(r2_r[R2_W-1:HALF]) * PP_W'(thr2_r);
    pl_r          <= PP_W'(r2_r[HALF-1:0]) * PP_W'(thr2_r);
  end

  assign load_ok = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    last_pr_nxt    = last_pr_r;
    job_pop        = 1'b0;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_range_nxt  = out_range_r;
    out_pruned_nxt = out_pruned_r;
    out_end_nxt    = out_end_r;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop     = 1'b1;
          job_nxt     = job_head;
          last_pr_nxt = 1'b0;
          state_nxt   = job_head.has_held ? ST_MUL1 : ST_EMIT2;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_SUB;
      ST_SUB:  state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_CMP;
      ST_CMP: begin
        if (load_ok) begin
          out_valid_nxt  = 1'b1;
          out_range_nxt  = job_r.a;
          out_pruned_nxt = pr;
          out_end_nxt    = 1'b0;
          last_pr_nxt    = pr || (job_r.a > cfg.max_range);
          state_nxt      = job_r.last ? ST_EMIT2 : ST_IDLE;
        end
      end
      ST_EMIT2: begin
        if (load_ok) begin
          out_valid_nxt  = 1'b1;
          out_range_nxt  = job_r.b;
          out_pruned_nxt = last_pr_r;
          out_end_nxt    = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    job_r        <= job_nxt;
    last_pr_r    <= last_pr_nxt;
    out_range_r  <= out_range_nxt;
    out_pruned_r <= out_pruned_nxt;
    out_end_r    <= out_end_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.range_out = out_range_r;
  assign out_chan.pruned    = out_pruned_r;
  assign out_chan.scan_end  = out_end_r;

endmodule

// ----- rtl/lidar_ray_incidence_pruner_top.sv -----
// The incidence unit works on one job at a time and pops no new job until it has emitted
//   that job's results (two for the closing pair of a scan, one for a one-ray scan); the
//   pace is set by the sequenced multiply chain.
// The input side keeps taking requests while the job queue has room.
// Reset (rst_n, synchronous, active low): nothing held, queue and output empty,
//   configuration registers back to their default values.
// ---------------------------------------------------------------------------
// lidar_ray_incidence_pruner_top
// Flags lidar rays whose incidence angle against the next ray is too shallow.
// ---------------------------------------------------------------------------
module lidar_ray_incidence_pruner_top #(
  parameter int QUEUE_DEPTH = lrip_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  lrip_in_if.sink     in_chan,
  lrip_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers; the user must write them only while the block is idle (the
  // block itself does not enforce it), so the incidence unit reads them directly.
  lrip_pkg::cfg_t cfg_r, cfg_nxt;

  // Front end -> queue -> incidence unit
  logic           q_push, q_pop, q_full, q_empty;
  lrip_pkg::job_t q_din, q_dout;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        lrip_pkg::REG_SIN_INC:   cfg_nxt.sin_inc   = cfg_wdata;
        lrip_pkg::REG_COS_INC:   cfg_nxt.cos_inc   = cfg_wdata[lrip_pkg::FRAC_BITS-1:0];
        lrip_pkg::REG_THRESHOLD: cfg_nxt.thr       = cfg_wdata[lrip_pkg::FRAC_BITS-1:0];
        lrip_pkg::REG_MAX_RANGE: cfg_nxt.max_range = cfg_wdata[lrip_pkg::RW-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sin_inc   <= lrip_pkg::SIN_INC_RST;
      cfg_r.cos_inc   <= lrip_pkg::COS_INC_RST;
      cfg_r.thr       <= lrip_pkg::THRESHOLD_RST;
      cfg_r.max_range <= lrip_pkg::MAX_RANGE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Hold one sample and pair it with the next range.
  lrip_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_din)
  );

  // Decouple the request side from the multiply sequence.
  lrip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  // Compare (b*sin_inc)^2 against thr^2 * r^2 and drive the output register.
  lrip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (!q_empty),
    .job_head  (q_dout),
    .job_pop   (q_pop),
    .out_chan  (out_chan)
  );

endmodule

// ----- dv/lidar_ray_incidence_pruner_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lidar_ray_incidence_pruner_top_tb
// Drives lidar scans through the pruner under a series of register settings
// and compares every result request against an exact integer model of the
// incidence test and of the closing rule at the end of each scan.
// ---------------------------------------------------------------------------
module lidar_ray_incidence_pruner_top_tb;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int NUM_PHASES  = 9;
  localparam int RAYS_PER_PHASE = 90;

  typedef struct packed {
    lrip_pkg::range_t range_out;
    logic             pruned;
    logic             scan_end;
  } ray_verdict_t;

  // Expected verdicts plus a private copy of the pruner's registers and
  // held ray, advanced on every accepted range request.
  class prune_scoreboard;
    logic [15:0]                    sin_inc;
    logic [lrip_pkg::FRAC_BITS-1:0] cos_inc;
    logic [lrip_pkg::FRAC_BITS-1:0] thr;
    lrip_pkg::range_t               max_range;
    lrip_pkg::range_t               held_ray;
    bit                             holding;
    ray_verdict_t                   verdicts[$];
    int                             errors;
    int                             rays;
    int                             scans;
    int                             results;
    int                             pruned_results;

    function new();
      sin_inc   = lrip_pkg::SIN_INC_RST;
      cos_inc   = lrip_pkg::COS_INC_RST;
      thr       = lrip_pkg::THRESHOLD_RST;
      max_range = lrip_pkg::MAX_RANGE_RST;
      holding   = 1'b0;
      held_ray  = '0;
      errors    = 0;
      rays      = 0;
      scans     = 0;
      results   = 0;
      pruned_results = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        lrip_pkg::REG_SIN_INC:   sin_inc   = value;
        lrip_pkg::REG_COS_INC:   cos_inc   = value[lrip_pkg::FRAC_BITS-1:0];
        lrip_pkg::REG_THRESHOLD: thr       = value[lrip_pkg::FRAC_BITS-1:0];
        lrip_pkg::REG_MAX_RANGE: max_range = value;
        default: ;
      endcase
    endfunction

    // Squared law-of-sines test: (b*sin)^2 < thr^2 * r^2, all in Q.15.
    function bit incidence_flag(lrip_pkg::range_t a, lrip_pkg::range_t b);
      logic [127:0] lhs, tot, cross_term, dist2, rhs;
      logic [16:0]  smag;
      logic [63:0]  lmag;
      bit           neg;
      neg  = sin_inc[15];
      smag = neg ? (17'h10000 - {1'b0, sin_inc}) : {1'b0, sin_inc};
      if (a == '0) return thr != '0;
      if (neg && b != '0 && smag != '0) return 1'b1;
      lmag  = neg ? 64'd0 : 64'(b) * 64'(smag);
      lhs   = (128'(lmag) * 128'(lmag)) << lrip_pkg::FRAC_BITS;
      tot   = (128'(a) * 128'(a) + 128'(b) * 128'(b)) << lrip_pkg::FRAC_BITS;
      cross_term = 128'(2) * 128'(a) * 128'(b) * 128'(cos_inc);
      dist2 = (tot < cross_term) ? 128'd0 : tot - cross_term;
      rhs   = dist2 * 128'(thr) * 128'(thr);
      return lhs < rhs;
    endfunction

    function void note_ray(lrip_pkg::range_t raw, bit is_last);
      lrip_pkg::range_t cur;
      bit               held_flag;
      ray_verdict_t     v;
      cur = raw & lrip_pkg::RANGE_MASK;
      held_flag = 1'b0;
      rays++;
      if (holding) begin
        held_flag   = incidence_flag(held_ray, cur);
        v.range_out = held_ray;
        v.pruned    = held_flag;
        v.scan_end  = 1'b0;
        verdicts.insert(verdicts.size(), v);
      end
      if (!is_last) begin
        held_ray = cur;
        holding  = 1'b1;
        return;
      end
      v.range_out = cur;
      v.pruned    = holding && (held_flag || held_ray > max_range);
      v.scan_end  = 1'b1;
      verdicts.insert(verdicts.size(), v);
      held_ray = '0;
      holding  = 1'b0;
      scans++;
    endfunction

    function void check_result(lrip_pkg::range_t r, logic p, logic e);
      ray_verdict_t want;
      results++;
      if (p) pruned_results++;
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result range=%0d pruned=%0b scan_end=%0b", $time, r, p, e);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (want.range_out !== r) begin
        $display("%0t: range_out mismatch: expected %0d, got %0d", $time, want.range_out, r);
        errors++;
      end
      if (want.pruned !== p) begin
        $display("%0t: pruned mismatch on range %0d: expected %0b, got %0b",
                 $time, want.range_out, want.pruned, p);
        errors++;
      end
      if (want.scan_end !== e) begin
        $display("%0t: scan_end mismatch on range %0d: expected %0b, got %0b",
                 $time, want.range_out, want.scan_end, e);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  lrip_in_if  in_chan();
  lrip_out_if out_chan();

  lidar_ray_incidence_pruner_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  prune_scoreboard sb = new();

  // Both sides idle unless this is set; some phases run flat out.
  bit no_idle = 1'b0;
  int cycle_count = 0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, sb.pending());
      $display("lidar_ray_incidence_pruner_top_tb: errors");
      $finish;
    end
  end

  // Mostly short stall lengths, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(15, 60);
  endfunction

  // Result side: hold ready high, drop it for random stalls.
  initial begin
    int stall_left;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0) stall_left = pick_gap();
      end
    end
  end

  // Check every result request as it leaves; sampled values are pre-edge.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      sb.check_result(out_chan.range_out, out_chan.pruned, out_chan.scan_end);
    end
  end

  // Present one range request and hold it until accepted. Entered and left at
  // a falling edge; valid stays high so back-to-back requests need no toggle.
  task automatic send_ray(lrip_pkg::range_t r, bit is_last);
    in_chan.valid        <= 1'b1;
    in_chan.range_mm     <= r;
    in_chan.last_in_scan <= is_last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_ray(r, is_last);
    @(negedge clk);
  endtask

  // Drop valid for a pause of length n (nothing when n is zero).
  task automatic pause_sender(int n);
    if (n > 0) begin
      in_chan.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_gapped(lrip_pkg::range_t r, bit is_last);
    send_ray(r, is_last);
    if (!no_idle && $urandom_range(0, 99) >= 60) pause_sender(pick_gap());
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Write all four registers on consecutive cycles; the block is idle here.
  task automatic write_settings(logic [15:0] s, logic [14:0] c, logic [14:0] t,
                                logic [15:0] m);
    logic [15:0] vals[4];
    vals[lrip_pkg::REG_SIN_INC]   = s;
    vals[lrip_pkg::REG_COS_INC]   = {1'($urandom_range(0, 1)), c};  // upper bit is ignored
    vals[lrip_pkg::REG_THRESHOLD] = {1'($urandom_range(0, 1)), t};
    vals[lrip_pkg::REG_MAX_RANGE] = m;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= 2'(i);
      cfg_wdata <= vals[i];
      sb.set_reg(2'(i), vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic lrip_pkg::range_t clamp_range(int v);
    if (v < 0) return '0;
    if (v > 65535) return 16'hFFFF;
    return lrip_pkg::range_t'(v);
  endfunction

  // Next range of a scan: mostly a smooth surface, with jumps, dropouts,
  // far returns and values near the configured maximum.
  function automatic lrip_pkg::range_t next_range(lrip_pkg::range_t prev);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return clamp_range(int'(prev) + $urandom_range(0, 400) - 200);
    if (r < 65) return clamp_range(int'(prev) + $urandom_range(0, 6000) - 3000);
    if (r < 77) return lrip_pkg::range_t'($urandom_range(0, 65535));
    if (r < 82) return '0;
    if (r < 86) return 16'hFFFF;
    if (r < 92) return lrip_pkg::range_t'($urandom_range(0, 255));
    return clamp_range(int'(sb.max_range) + $urandom_range(0, 4) - 2);
  endfunction

  // Pick a register setting per phase: the extremes first, then random ones.
  task automatic configure_phase(int phase);
    case (phase)
      1: write_settings(16'h8000, 15'd0, 15'h7FFF, 16'd0);
      2: write_settings(16'h7FFF, 15'h7FFF, 15'd0, 16'hFFFF);
      3: write_settings(16'h0000, 15'd16384, 15'd1, 16'd1000);
      4: write_settings(16'hFFFF, 15'h7FFF, 15'd18055, 16'd5600);
      5: write_settings(16'd143, 15'h7FFF, 15'h7FFF, 16'd30000);
      default: begin
        if ($urandom_range(0, 1) == 1)
          write_settings(16'($urandom_range(20, 900)), 15'($urandom_range(30000, 32767)),
                         15'($urandom), 16'($urandom));
        else
          write_settings(16'($urandom), 15'($urandom), 15'($urandom), 16'($urandom));
      end
    endcase
  endtask

  initial begin
    int               phase_rays;
    int               scan_len;
    int               r;
    lrip_pkg::range_t cur;

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = lrip_pkg::REG_SIN_INC;
    cfg_wdata            = '0;
    in_chan.valid        = 1'b0;
    in_chan.range_mm     = '0;
    in_chan.last_in_scan = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed scans on the reset settings.
    send_gapped(16'd0, 1'b1);        // one-ray scan, zero range
    send_gapped(16'hFFFF, 1'b1);     // one-ray scan, full range
    send_gapped(16'd0, 1'b0);        // zero first range: pruned when threshold > 0
    send_gapped(16'd4000, 1'b0);
    send_gapped(16'd4010, 1'b1);
    send_gapped(16'd3000, 1'b0);     // smooth wall ending in a sharp jump
    send_gapped(16'd3005, 1'b0);
    send_gapped(16'd3010, 1'b0);
    send_gapped(16'd9000, 1'b1);
    send_gapped(16'hFFFF, 1'b0);     // held ray beyond max range on the last pair
    send_gapped(16'hFFFF, 1'b0);
    send_gapped(16'hFFFF, 1'b1);
    send_gapped(16'd1, 1'b0);
    send_gapped(16'hFFFF, 1'b0);
    send_gapped(16'd0, 1'b0);
    send_gapped(16'd1, 1'b1);
    send_gapped(16'd5600, 1'b0);     // exactly at max range
    send_gapped(16'd5600, 1'b1);
    send_gapped(16'd5601, 1'b0);     // one past max range
    send_gapped(16'd5601, 1'b1);
    drain();

    for (int phase = 1; phase < NUM_PHASES; phase++) begin
      // Let any work still inside the block settle before touching registers.
      repeat (20) @(negedge clk);
      configure_phase(phase);
      no_idle = (phase % 4 == 2);

      // Short directed burst under the new setting.
      send_gapped(16'd0, 1'b0);
      send_gapped(16'd500, 1'b1);
      send_gapped(16'd500, 1'b0);    // next range zero: negative sine no longer forces
      send_gapped(16'd0, 1'b0);
      send_gapped(16'd700, 1'b1);
      send_gapped(16'd1234, 1'b1);
      send_gapped(sb.max_range, 1'b0);
      send_gapped(clamp_range(int'(sb.max_range) + 1), 1'b1);

      // Random scans.
      phase_rays = 0;
      cur = lrip_pkg::range_t'($urandom_range(200, 20000));
      while (phase_rays < RAYS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 10) scan_len = 1;
        else if (r < 85) scan_len = $urandom_range(2, 24);
        else scan_len = $urandom_range(25, 80);
        for (int i = 0; i < scan_len; i++) begin
          cur = next_range(cur);
          send_gapped(cur, i == scan_len - 1);
          phase_rays++;
          // Now and then wait for the block to empty, even mid-scan.
          if ($urandom_range(0, 59) == 0) drain();
        end
      end
      drain();
    end

    // Wait out any stray result.
    repeat (30) @(negedge clk);

    $display("covered %0d rays in %0d scans over %0d register settings",
             sb.rays, sb.scans, NUM_PHASES);
    $display("checked %0d results, %0d of them pruned", sb.results, sb.pruned_results);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("lidar_ray_incidence_pruner_top_tb: clean");
    end else begin
      $display("lidar_ray_incidence_pruner_top_tb: errors");
    end
    $finish;
  end

endmodule
